// ----- rtl/core/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg: shared types for the per-symbol trade statistics table
// Request/response structs, status codes and the divider handshake struct.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned QTY_W   = 24;
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned VOL_W   = 40;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned PROD_W  = 48;

  typedef enum logic [0:0] {
    REQ_TRADE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [0:0]         req_type;
    logic [KEY_W-1:0]   symbol_code;
    logic [TIME_W-1:0]  trade_time;
    logic [QTY_W-1:0]   trade_quantity;
    logic [PRICE_W-1:0] trade_price;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TIME_W-1:0]  largest_gap;
    logic [VOL_W-1:0]   volume_total;
    logic [PRICE_W-1:0] average_price;
    logic [PRICE_W-1:0] highest_price;
  } out_item_t;

  // one stored entry (key kept in its own memory)
  typedef struct packed {
    logic [TIME_W-1:0]  last_time;
    logic [TIME_W-1:0]  gap_max;
    logic [VOL_W-1:0]   volume_sum;
    logic [VAL_W-1:0]   value_sum;
    logic [PRICE_W-1:0] price_max;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VOL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [PRICE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/pst_divider.sv -----
// ----------------------------------------------------------------------------
// pst_divider: radix-2 restoring divider, 64 / 40 bits
// One quotient bit per cycle; result saturated to 24 bits.
// ----------------------------------------------------------------------------
module pst_divider
  import pst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [VAL_W-1:0]   quo_r, quo_nxt;
  logic [VOL_W:0]     rem_r, rem_nxt;
  logic [VOL_W-1:0]   dvs_r, dvs_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [VOL_W:0]     trial;
  logic [VOL_W+1:0]   diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[VOL_W-1:0], quo_r[VAL_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'(VAL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below divisor, so trial fits VOL_W+1 bits
      if (!diff[VOL_W+1]) begin
        rem_nxt = diff[VOL_W:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = (quo_r[VAL_W-1:PRICE_W] != '0) ? '1 : quo_r[PRICE_W-1:0];

endmodule

// ----- rtl/core/per_symbol_trade_stats_table_unit.sv -----
// ----------------------------------------------------------------------------
// per_symbol_trade_stats_table_unit: per-symbol trade statistics table
// Keyed table of trade totals with lookup, allocate and update, and queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request transactions (trade or query), valid/stall handshake.
//   out_* : one result transaction per request, valid/stall handshake.
// A request is handled one at a time. The key memory is scanned one entry
// per cycle over the allocated entries, then the stats memory is read,
// updated and written back. Every result with a nonzero volume runs the
// 64-bit average divider, one quotient bit per cycle.
// Reset empties the table at once: the fill count goes to zero and only
// entries below it are ever read, so no clearing pass is needed.
// While out_stall is high the finished result is held in the output register;
// a new request is taken once the result has left (in_stall low in IDLE).
// ----------------------------------------------------------------------------
module per_symbol_trade_stats_table_unit
  import pst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_READ  = 6'b000100,
    S_UPD   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  entry_t           ent_mem [TABLE_ENTRIES];

  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;   // next key address issued
  logic             kvld_r;             // key read data valid for kidx_r
  logic [IDX_W-1:0] kidx_r;
  logic [KEY_W-1:0] key_rd_r;
  entry_t           ent_rd_r;
  in_item_t         req_r;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             alloc_r, alloc_nxt;
  out_item_t        out_r, out_nxt;
  logic             oval_r, oval_nxt;

  logic             key_rd_en;
  logic             ent_wr_en, key_wr_en;
  entry_t           ent_wdata;
  entry_t           cur;
  entry_t           upd_sel;
  div_req_t         dreq;
  div_rsp_t         drsp;

  // update arithmetic
  logic [PROD_W-1:0]  prod;
  logic [VOL_W:0]     vol_add;
  logic [VAL_W:0]     val_add;
  logic [TIME_W-1:0]  gap;
  entry_t             upd;

  always_ff @(posedge clk) begin
    if (key_rd_en) key_rd_r <= key_mem[scan_r[IDX_W-1:0]];
    if (key_wr_en) key_mem[slot_r] <= req_r.symbol_code;
    ent_rd_r <= ent_mem[slot_r];
    if (ent_wr_en) ent_mem[slot_r] <= ent_wdata;
  end

  assign key_rd_en = (state_r == S_SCAN) && (scan_r < used_r);

  // a freshly allocated entry reads as zero
  assign cur = alloc_r ? '0 : ent_rd_r;

  always_comb begin
    prod    = PROD_W'(req_r.trade_quantity) * PROD_W'(req_r.trade_price);
    vol_add = {1'b0, cur.volume_sum} + (VOL_W+1)'(req_r.trade_quantity);
    val_add = {1'b0, cur.value_sum} + (VAL_W+1)'(prod);
    gap     = req_r.trade_time - cur.last_time;
    upd            = cur;
    upd.last_time  = req_r.trade_time;
    if (cur.last_time != '0 && req_r.trade_time > cur.last_time && gap > cur.gap_max)
      upd.gap_max = gap;
    upd.volume_sum = vol_add[VOL_W] ? '1 : vol_add[VOL_W-1:0];
    upd.value_sum  = val_add[VAL_W] ? '1 : val_add[VAL_W-1:0];
    if (req_r.trade_price > cur.price_max) upd.price_max = req_r.trade_price;
  end

  // query shows the stored entry, trade shows it after update;
  // read data is valid in S_UPD
  assign upd_sel = (req_r.req_type == REQ_TRADE) ? upd : cur;

  assign ent_wdata = upd;
  assign ent_wr_en = (state_r == S_UPD) && (req_r.req_type == REQ_TRADE);
  assign key_wr_en = ent_wr_en && alloc_r;

  pst_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    scan_nxt  = scan_r;
    slot_nxt  = slot_r;
    alloc_nxt = alloc_r;
    out_nxt   = out_r;
    oval_nxt  = oval_r;
    dreq      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !oval_r) begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_rd_en) scan_nxt = scan_r + CNT_W'(1);
        if (kvld_r && key_rd_r == req_r.symbol_code) begin
          slot_nxt  = kidx_r;
          alloc_nxt = 1'b0;
          state_nxt = S_READ;
        end else if (!key_rd_en && !kvld_r) begin
          // search missed
          out_nxt = '0;
          if (req_r.req_type == REQ_QUERY) begin
            out_nxt.status = ST_NOT_FOUND;
            oval_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (used_r >= CNT_W'(TABLE_ENTRIES)) begin
            out_nxt.status = ST_FULL;
            oval_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            slot_nxt  = used_r[IDX_W-1:0];
            alloc_nxt = 1'b1;
            used_nxt  = used_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_UPD;
      S_UPD: begin
        out_nxt.status        = ST_OK;
        out_nxt.largest_gap   = upd_sel.gap_max;
        out_nxt.volume_total  = upd_sel.volume_sum;
        out_nxt.highest_price = upd_sel.price_max;
        out_nxt.average_price = '0;
        if (upd_sel.volume_sum != '0) begin
          dreq.start    = 1'b1;
          dreq.dividend = upd_sel.value_sum;
          dreq.divisor  = upd_sel.volume_sum;
          state_nxt     = S_DIV;
        end else begin
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          out_nxt.average_price = drsp.quotient;
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (oval_r && !out_stall) oval_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      oval_r  <= 1'b0;
      kvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      oval_r  <= oval_nxt;
      kvld_r  <= key_rd_en;
    end
    scan_r  <= scan_nxt;
    kidx_r  <= scan_r[IDX_W-1:0];
    slot_r  <= slot_nxt;
    alloc_r <= alloc_nxt;
    out_r   <= out_nxt;
    if (state_r == S_IDLE) req_r <= in_data;
  end

  assign in_stall  = (state_r != S_IDLE) || oval_r;
  assign out_valid = oval_r;
  assign out_data  = out_r;

endmodule
